[rtl/hsd_pkg.sv]
`default_nettype none
package hsd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned OFFS_W   = 6;
  localparam int unsigned CFG_AW   = 3;
  localparam int unsigned CFG_DW   = 8;
  localparam int unsigned DEF_MAX_PAYLOAD = 64;

  localparam logic [CFG_AW-1:0] REG_SYNC_FIRST   = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SYNC_SECOND  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_DATA_TYPE    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_CMD_TYPE     = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DATA_LENGTH  = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RESET_CMD    = 3'd5;
  localparam logic [CFG_AW-1:0] REG_ABORT_CMD    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CALIB_CMD    = 3'd7;

  localparam logic [BYTE_W-1:0] RST_SYNC_FIRST  = 8'h55;
  localparam logic [BYTE_W-1:0] RST_SYNC_SECOND = 8'hAA;
  localparam logic [BYTE_W-1:0] RST_DATA_TYPE   = 8'h01;
  localparam logic [BYTE_W-1:0] RST_CMD_TYPE    = 8'h02;
  localparam logic [LEN_W-1:0]  RST_DATA_LENGTH = 7'd64;
  localparam logic [BYTE_W-1:0] RST_RESET_CMD   = 8'h00;
  localparam logic [BYTE_W-1:0] RST_ABORT_CMD   = 8'h01;
  localparam logic [BYTE_W-1:0] RST_CALIB_CMD   = 8'h02;

  typedef struct packed {
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic [BYTE_W-1:0] data_type_code;
    logic [BYTE_W-1:0] command_type_code;
    logic [LEN_W-1:0]  data_length;
    logic [BYTE_W-1:0] reset_cmd_code;
    logic [BYTE_W-1:0] abort_cmd_code;
    logic [BYTE_W-1:0] calib_cmd_code;
  } cfg_t;

  typedef struct packed {
    logic              is_command;
    logic [BYTE_W-1:0] payload_value;
    logic [OFFS_W-1:0] byte_offset;
    logic              last_of_packet;
    logic              accepted;
  } res_t;

endpackage
`default_nettype wire

[rtl/hsd_cfg.sv]
`default_nettype none
module hsd_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hsd_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [hsd_pkg::CFG_DW-1:0] cfg_wdata,
  output hsd_pkg::cfg_t                   cfg
);
  import hsd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SYNC_FIRST:  cfg_nxt.sync_first        = cfg_wdata;
        REG_SYNC_SECOND: cfg_nxt.sync_second       = cfg_wdata;
        REG_DATA_TYPE:   cfg_nxt.data_type_code    = cfg_wdata;
        REG_CMD_TYPE:    cfg_nxt.command_type_code = cfg_wdata;
        REG_DATA_LENGTH: cfg_nxt.data_length       = cfg_wdata[LEN_W-1:0];
        REG_RESET_CMD:   cfg_nxt.reset_cmd_code    = cfg_wdata;
        REG_ABORT_CMD:   cfg_nxt.abort_cmd_code    = cfg_wdata;
        REG_CALIB_CMD:   cfg_nxt.calib_cmd_code    = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first        <= RST_SYNC_FIRST;
      cfg_r.sync_second       <= RST_SYNC_SECOND;
      cfg_r.data_type_code    <= RST_DATA_TYPE;
      cfg_r.command_type_code <= RST_CMD_TYPE;
      cfg_r.data_length       <= RST_DATA_LENGTH;
      cfg_r.reset_cmd_code    <= RST_RESET_CMD;
      cfg_r.abort_cmd_code    <= RST_ABORT_CMD;
      cfg_r.calib_cmd_code    <= RST_CALIB_CMD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

[rtl/hsd_parse.sv]
`default_nettype none
module hsd_parse #(
  parameter int unsigned MAX_PAYLOAD = hsd_pkg::DEF_MAX_PAYLOAD
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire hsd_pkg::cfg_t              cfg,
  input  wire logic                       in_fire,
  input  wire logic [hsd_pkg::BYTE_W-1:0] rx_byte,
  output logic                            res_valid,
  output hsd_pkg::res_t                   res
);
  import hsd_pkg::*;

  localparam int unsigned CNT_W = (MAX_PAYLOAD > 2) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HDR1    = 2'd1,
    PH_HDR2    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic             kind_r, kind_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W:0]   count;
  logic             last;
  logic             cmd_ok;

  always_comb begin
    eff_len = cfg.data_length;
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end
    if (eff_len > MAX_LEN) begin
      eff_len = MAX_LEN;
    end
  end

  assign count  = (LEN_W+1)'(cnt_r) + (LEN_W+1)'(1);
  assign last   = count >= {1'b0, eff_len};
  assign cmd_ok = (rx_byte == cfg.reset_cmd_code) || (rx_byte == cfg.abort_cmd_code) ||
                  (rx_byte == cfg.calib_cmd_code);

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res.is_command     = kind_r;
    res.payload_value  = rx_byte;
    res.byte_offset    = '0;
    res.last_of_packet = 1'b1;
    res.accepted       = cmd_ok;
    if (in_fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (rx_byte == cfg.sync_first) begin
            phase_nxt = PH_HDR1;
          end
        end
        PH_HDR1: begin
          if (rx_byte == cfg.sync_second) begin
            phase_nxt = PH_HDR2;
          end else if (rx_byte != cfg.sync_first) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_HDR2: begin
          cnt_nxt = '0;
          if (rx_byte == cfg.data_type_code) begin
            kind_nxt  = 1'b0;
            phase_nxt = PH_PAYLOAD;
          end else if (rx_byte == cfg.command_type_code) begin
            kind_nxt  = 1'b1;
            phase_nxt = PH_PAYLOAD;
          end else begin
            kind_nxt  = 1'b0;
            phase_nxt = PH_IDLE;
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          if (kind_r) begin
            phase_nxt = PH_IDLE;
            kind_nxt  = 1'b0;
            cnt_nxt   = '0;
          end else begin
            res.byte_offset    = OFFS_W'(cnt_r);
            res.last_of_packet = last;
            res.accepted       = last;
            if (last) begin
              phase_nxt = PH_IDLE;
              kind_nxt  = 1'b0;
              cnt_nxt   = '0;
            end else begin
              cnt_nxt = count[CNT_W-1:0];
            end
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      kind_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[rtl/hsd_out.sv]
`default_nettype none
module hsd_out (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire hsd_pkg::res_t res,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  output hsd_pkg::res_t out_res
);
  import hsd_pkg::*;

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop = main_valid_r & out_ready;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (skid_valid_r) begin
      if (pop) begin
        main_nxt       = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_valid_r || pop) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      main_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign in_ready  = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

endmodule
`default_nettype wire

[rtl/header_sync_packet_deframer.sv]
`default_nettype none
// channel   direction  payload
// in_       slave      tdata[7:0] rx_byte
// out_      master     tdata payload/offset/accepted, tuser is_command, tlast last_of_packet
// cfg_      write      cfg_addr register index, cfg_wdata value
//
// one byte per cycle while in_tready is high; each result is registered in the output buffer before it appears on out_
// state machine and offset counter update in the same cycle as the transfer
// a two-entry output buffer takes one more transfer during an out_ stall;
// in_tready then stays low until the held result moves up, after out_ accepts the result ahead of it
// synchronous active-low reset: idle phase, offset counter cleared, output buffer emptied, registers to defaults
module header_sync_packet_deframer #(
  parameter int unsigned MAX_PAYLOAD = hsd_pkg::DEF_MAX_PAYLOAD
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] rx_byte
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [15:0]                     out_tdata,  // [7:0] payload_value, [13:8] byte_offset,
                                                      // [14] accepted, [15] zero
  output logic                            out_tuser,  // [0] is_command
  output logic                            out_tlast,
  input  wire logic                       cfg_wr_en,
  input  wire logic [hsd_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [hsd_pkg::CFG_DW-1:0] cfg_wdata
);
  import hsd_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t out_res;
  logic res_valid;
  logic in_fire;

  assign in_fire = in_tvalid & in_tready;

  hsd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  hsd_parse #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_fire   (in_fire),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  hsd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .res       (res),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {1'b0, out_res.accepted, out_res.byte_offset, out_res.payload_value};
  assign out_tuser = out_res.is_command;
  assign out_tlast = out_res.last_of_packet;

`ifndef SYNTH
  a_skid_implies_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("output buffer backpressure without held result");

  a_data_accept_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[14] == out_tlast))
    else $error("data byte accepted flag differs from last flag");

  a_cmd_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tlast && out_tdata[13:8] == '0))
    else $error("command result not last or nonzero offset");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("output buffer not empty after reset");
`endif

endmodule
`default_nettype wire
